// ===== rtl/twdiv_pkg.sv =====
// Package: shared defaults and control types for the two-word by one-word divider.
package twdiv_pkg;

  localparam int unsigned WordBitsDef = 32;

  typedef struct packed {
    logic valid;
    logic invalid;
  } twdiv_ctrl_t;

endpackage

// ===== rtl/twdiv_stage.sv =====
// One restoring-division step: produces one quotient bit, registered.
module twdiv_stage #(
  parameter int unsigned WORD_BITS = twdiv_pkg::WordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  twdiv_pkg::twdiv_ctrl_t ctrl_i,
  input  logic [WORD_BITS-1:0]   rem_i,
  input  logic [WORD_BITS-1:0]   bits_i,
  input  logic [WORD_BITS-1:0]   div_i,
  output twdiv_pkg::twdiv_ctrl_t ctrl_o,
  output logic [WORD_BITS-1:0]   rem_o,
  output logic [WORD_BITS-1:0]   bits_o,
  output logic [WORD_BITS-1:0]   div_o
);
  import twdiv_pkg::*;

  twdiv_ctrl_t          ctrl_q;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] bits_q, bits_d;
  logic [WORD_BITS-1:0] div_q;
  logic [WORD_BITS-1:0] shifted;
  logic                 take;

  // bits_i: remaining dividend bits on top, quotient bits fill in from the bottom
  always_comb begin
    shifted = {rem_i[WORD_BITS-2:0], bits_i[WORD_BITS-1]};
    take    = rem_i[WORD_BITS-1] || (shifted >= div_i);
    rem_d   = take ? (shifted - div_i) : shifted;
    bits_d  = {bits_i[WORD_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.valid) begin
      rem_q  <= rem_d;
      bits_q <= bits_d;
      div_q  <= div_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign bits_o = bits_q;
  assign div_o  = div_q;

endmodule

// ===== rtl/twdiv_skid.sv =====
// Output register with one skid entry; applies the invalid-result override.
module twdiv_skid #(
  parameter int unsigned WORD_BITS = twdiv_pkg::WordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  twdiv_pkg::twdiv_ctrl_t ctrl_i,
  input  logic [WORD_BITS-1:0]   quot_i,
  input  logic [WORD_BITS-1:0]   rem_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [WORD_BITS-1:0]   quotient_o,
  output logic [WORD_BITS-1:0]   remainder_o,
  output logic                   invalid_o
);
  import twdiv_pkg::*;

  logic                 out_valid_q, skid_valid_q;
  logic [WORD_BITS-1:0] out_quot_q, out_rem_q, skid_quot_q, skid_rem_q;
  logic                 out_inv_q, skid_inv_q;
  logic [WORD_BITS-1:0] new_quot, new_rem;
  logic                 in_take, out_free;

  assign ready_o  = !skid_valid_q;
  assign in_take  = ready_o && ctrl_i.valid;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    new_quot = ctrl_i.invalid ? '1 : quot_i;
    new_rem  = ctrl_i.invalid ? '0 : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= skid_valid_q || in_take;
        skid_valid_q <= 1'b0;
      end else if (in_take) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_quot_q <= skid_quot_q;
        out_rem_q  <= skid_rem_q;
        out_inv_q  <= skid_inv_q;
      end else if (in_take) begin
        out_quot_q <= new_quot;
        out_rem_q  <= new_rem;
        out_inv_q  <= ctrl_i.invalid;
      end
    end else if (in_take) begin
      skid_quot_q <= new_quot;
      skid_rem_q  <= new_rem;
      skid_inv_q  <= ctrl_i.invalid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quotient_o  = out_quot_q;
  assign remainder_o = out_rem_q;
  assign invalid_o   = out_inv_q;

endmodule

// ===== rtl/two_word_by_word_divider_top.sv =====
// Top level: pipelined restoring divider, two-word dividend by one-word divisor.
//
//   channel | direction | handshake               | words
//   in      | input     | in_valid_i / in_ready_o  | dividend_high_i, dividend_low_i, divisor_i
//   out     | output    | out_valid_o / out_ready_i| quotient_o, remainder_o, invalid_o
//
// One word per cycle sustained while the output is not stalled; the path runs through a check register,
// one register stage per quotient bit, then the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output parks one result in a skid entry; in_ready_o drops while it is
// full and the whole pipeline holds, so nothing is lost or repeated.
module two_word_by_word_divider_top #(
  parameter int unsigned WORD_BITS = twdiv_pkg::WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] dividend_high_i,
  input  logic [WORD_BITS-1:0] dividend_low_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] quotient_o,
  output logic [WORD_BITS-1:0] remainder_o,
  output logic                 invalid_o
);
  import twdiv_pkg::*;

  twdiv_ctrl_t          ctrl_s [WORD_BITS+1];
  logic [WORD_BITS-1:0] rem_s  [WORD_BITS+1];
  logic [WORD_BITS-1:0] bits_s [WORD_BITS+1];
  logic [WORD_BITS-1:0] div_s  [WORD_BITS+1];

  twdiv_ctrl_t          chk_ctrl_q;
  logic [WORD_BITS-1:0] chk_hi_q, chk_lo_q, chk_div_q;
  logic                 en;

  // check stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_ctrl_q <= '0;
    end else if (en) begin
      chk_ctrl_q.valid   <= in_valid_i;
      chk_ctrl_q.invalid <= (divisor_i == '0) || (dividend_high_i >= divisor_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      chk_hi_q  <= dividend_high_i;
      chk_lo_q  <= dividend_low_i;
      chk_div_q <= divisor_i;
    end
  end

  assign ctrl_s[0] = chk_ctrl_q;
  assign rem_s[0]  = chk_hi_q;
  assign bits_s[0] = chk_lo_q;
  assign div_s[0]  = chk_div_q;

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_stage
    twdiv_stage #(.WORD_BITS(WORD_BITS)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[g]),
      .rem_i  (rem_s[g]),
      .bits_i (bits_s[g]),
      .div_i  (div_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .bits_o (bits_s[g+1]),
      .div_o  (div_s[g+1])
    );
  end

  twdiv_skid #(.WORD_BITS(WORD_BITS)) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_s[WORD_BITS]),
    .quot_i      (bits_s[WORD_BITS]),
    .rem_i       (rem_s[WORD_BITS]),
    .ready_o     (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quotient_o  (quotient_o),
    .remainder_o (remainder_o),
    .invalid_o   (invalid_o)
  );

  assign in_ready_o = en;

`ifndef SYNTHESIS
  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctrl_s[WORD_BITS]))
    else $error("pipeline moved while stalled");

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> out_valid_o)
    else $error("skid entry full with empty output register");

  a_invalid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |-> (quotient_o == '1 && remainder_o == '0))
    else $error("invalid result not forced");

  a_valid_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_s[WORD_BITS].valid && !ctrl_s[WORD_BITS].invalid)
      |-> (rem_s[WORD_BITS] < div_s[WORD_BITS]))
    else $error("remainder not below divisor");
`endif

endmodule

// ===== dv/twdiv_checker.sv =====
// Checker: predicts every division of the two-word divider and compares each result word.
`timescale 1ns / 1ps
module twdiv_checker #(
  parameter int unsigned WORD_BITS = twdiv_pkg::WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [WORD_BITS-1:0] dividend_high_i,
  input  logic [WORD_BITS-1:0] dividend_low_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [WORD_BITS-1:0] quotient_i,
  input  logic [WORD_BITS-1:0] remainder_i,
  input  logic                 invalid_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [WORD_BITS-1:0] quotient;
    logic [WORD_BITS-1:0] remainder;
    logic                 invalid;
  } div_result_t;

  div_result_t quot_rem_q[$];

  function automatic div_result_t restoring_divide(input logic [WORD_BITS-1:0] hi,
                                                   input logic [WORD_BITS-1:0] lo,
                                                   input logic [WORD_BITS-1:0] d);
    div_result_t          res;
    logic [WORD_BITS-1:0] rem;
    logic                 carry;
    res.quotient  = '1;
    res.remainder = '0;
    res.invalid   = 1'b1;
    if (d != '0 && hi < d) begin
      rem          = hi;
      res.quotient = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
        carry = rem[WORD_BITS-1];
        rem   = {rem[WORD_BITS-2:0], lo[j]};
        if (carry || rem >= d) begin
          res.quotient[j] = 1'b1;
          rem             = rem - d;
        end
      end
      res.remainder = rem;
      res.invalid   = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    div_result_t want;
    int          fails;
    if (!rst_ni) begin
      quot_rem_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      fails = fail_count_o;
      if (out_valid_i && out_ready_i) begin
        if (quot_rem_q.size() == 0) begin
          $display("%t unexpected result word: quotient %h remainder %h invalid %b",
                   $time, quotient_i, remainder_i, invalid_i);
          fails++;
        end else begin
          want = quot_rem_q.pop_front();
          if (quotient_i !== want.quotient) begin
            $display("%t quotient mismatch: expected %h actual %h",
                     $time, want.quotient, quotient_i);
            fails++;
          end
          if (remainder_i !== want.remainder) begin
            $display("%t remainder mismatch: expected %h actual %h",
                     $time, want.remainder, remainder_i);
            fails++;
          end
          if (invalid_i !== want.invalid) begin
            $display("%t invalid mismatch: expected %b actual %b",
                     $time, want.invalid, invalid_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        quot_rem_q.push_back(restoring_divide(dividend_high_i, dividend_low_i, divisor_i));
      fail_count_o <= fails;
      pending_o    <= quot_rem_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives division words into the divider, stalls the output, gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned W       = twdiv_pkg::WordBitsDef;
  localparam int unsigned LATENCY = W + 2;

  typedef logic [W-1:0] word_t;

  logic  clk_i           = 1'b0;
  logic  rst_ni          = 1'b0;
  logic  in_valid_i      = 1'b0;
  logic  out_ready_i     = 1'b0;
  word_t dividend_high_i = '0;
  word_t dividend_low_i  = '0;
  word_t divisor_i       = '0;
  logic  in_ready_o;
  logic  out_valid_o;
  word_t quotient_o;
  word_t remainder_o;
  logic  invalid_o;
  int    fail_count;
  int    pending;
  bit    no_idle = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  two_word_by_word_divider_top #(.WORD_BITS(W)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .dividend_high_i(dividend_high_i),
    .dividend_low_i (dividend_low_i),
    .divisor_i      (divisor_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .quotient_o     (quotient_o),
    .remainder_o    (remainder_o),
    .invalid_o      (invalid_o)
  );

  twdiv_checker #(.WORD_BITS(W)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .dividend_high_i(dividend_high_i),
    .dividend_low_i (dividend_low_i),
    .divisor_i      (divisor_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .quotient_i     (quotient_o),
    .remainder_i    (remainder_o),
    .invalid_i      (invalid_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic int unsigned gap_cycles();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_division(input word_t hi, input word_t lo, input word_t d);
    int unsigned n;
    in_valid_i      <= 1'b1;
    dividend_high_i <= hi;
    dividend_low_i  <= lo;
    divisor_i       <= d;
    do @(posedge clk_i); while (!in_ready_o);
    n = gap_cycles();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_division();
    int unsigned kind;
    word_t       hi;
    word_t       lo;
    word_t       d;
    kind = $urandom_range(0, 99);
    d    = word_t'($urandom) >> $urandom_range(0, W - 1);
    if (kind < 8) d = '1 - word_t'($urandom_range(0, 3));
    if (d == '0) d = 1;
    case ($urandom_range(0, 9))
      0:       lo = '0;
      1:       lo = '1;
      default: lo = $urandom;
    endcase
    if (kind < 85) begin
      case ($urandom_range(0, 9))
        0:       hi = '0;
        1:       hi = d - 1;
        default: hi = $urandom_range(0, d - 1);
      endcase
    end else if (kind < 90) begin
      d  = '0;
      hi = $urandom;
    end else if (kind < 94) begin
      hi = d;
    end else begin
      hi = $urandom_range(32'hFFFF_FFFF, d);
    end
    send_division(hi, lo, d);
  endtask

  initial begin : ready_driver
    int unsigned n;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      n = gap_cycles();
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_division('0, '0, 32'h0000_0001);
    send_division('0, '1, 32'h0000_0001);
    send_division(32'hFFFF_FFFE, '1, '1);
    send_division('0, '0, '1);
    send_division('0, '1, '1);
    send_division(32'h7FFF_FFFF, '1, 32'h8000_0000);
    send_division(32'hFFFF_FFFE, '0, '1);
    send_division(32'h8000_0000, 32'h8000_0000, 32'hC000_0001);
    send_division(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAB);
    send_division(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5556);
    send_division(32'h0000_0001, '0, 32'h0000_0002);
    send_division('0, 32'h8000_0000, 32'h0000_0003);
    send_division('0, 32'h1234_5678, '0);
    send_division('0, '0, '0);
    send_division('1, '1, '0);
    send_division('1, '1, '1);
    send_division('1, '1, 32'h8000_0000);
    send_division(32'h0000_0005, 32'h0000_0007, 32'h0000_0005);
    drain_results();

    for (int i = 0; i < 650; i++) begin
      no_idle = ((i / 130) % 2) == 1;
      if (i % 200 == 199) drain_results();
      send_random_division();
    end
    no_idle = 1'b0;

    drain_results();
    repeat (LATENCY + 6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
